// ===== rtl/credit_based_shaper_macros.svh =====
// Assertion macros used by the shaper controller
`ifndef CREDIT_BASED_SHAPER_MACROS_SVH
`define CREDIT_BASED_SHAPER_MACROS_SVH
// Implication checked on every rising clock edge out of reset
`define CBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define CBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/cbs_pkg.sv =====
// Package: shared types and constants of the credit-based shaper
`default_nettype none
package cbs_pkg;
  localparam int unsigned QueueDepthDef = 256;
  localparam int unsigned DivBits = 32;

  typedef enum logic [1:0] {
    KIND_ARRIVAL = 2'd0,
    KIND_WAKEUP  = 2'd1,
    KIND_TX      = 2'd2,
    KIND_IDLE    = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    CFG_IDLE_SLOPE = 1'b0,
    CFG_PORT_RATE  = 1'b1
  } cfg_idx_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // latch the event and the first update step
    logic mul2;       // second update step (after the product)
    logic decide;     // commit state and produce result
    logic div_start;  // begin division
    logic div_step;   // one quotient bit
    logic finish;     // capture result register
  } cbs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
  } cbs_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/cbs_if.sv =====
// Valid/ready channel interfaces for events and results
`default_nettype none
interface cbs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] elapsed_ticks;
  logic [15:0] tx_duration;
  modport source (output valid, kind, elapsed_ticks, tx_duration, input ready);
  modport sink (input valid, kind, elapsed_ticks, tx_duration, output ready);
endinterface

interface cbs_out_if;
  logic               valid;
  logic               ready;
  logic               release_frame;
  logic               wait_valid;
  logic [31:0]        wait_ticks;
  logic signed [31:0] credit_now;
  logic signed [31:0] max_credit_now;
  logic               queue_flushed;
  logic               arrival_dropped;
  modport source (output valid, release_frame, wait_valid, wait_ticks, credit_now,
                  max_credit_now, queue_flushed, arrival_dropped, input ready);
  modport sink (input valid, release_frame, wait_valid, wait_ticks, credit_now,
                max_credit_now, queue_flushed, arrival_dropped, output ready);
endinterface
`default_nettype wire

// ===== rtl/cbs_ctrl.sv =====
// Controller: sequences one event through the shaper datapath
`default_nettype none
module cbs_ctrl
  import cbs_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire       out_ready,
  output cbs_cmd_t  cmd,
  input  cbs_sts_t  sts
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_DEC  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Accept only when idle: no event in flight and no result pending
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul2 = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

`include "credit_based_shaper_macros.svh"
  `CBS_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_r))
  `CBS_ASSERT_NXT(a_load_mul, clk, rst_n, cmd.load, state_r == S_MUL)
  `CBS_ASSERT_IMP(a_hold_out, clk, rst_n, out_valid && !out_ready, state_nxt == S_OUT)
endmodule
`default_nettype wire

// ===== rtl/cbs_dp.sv =====
// Datapath: shaper state, credit arithmetic and wait-time divider
`default_nettype none
module cbs_dp
  import cbs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  localparam int unsigned QW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire                cfg_index,
  input  wire  [15:0]        cfg_wdata,
  input  wire  [1:0]         kind_i,
  input  wire  [15:0]        elapsed_i,
  input  wire  [15:0]        dur_i,
  input  cbs_cmd_t           cmd,
  output cbs_sts_t           sts,
  output logic               release_o,
  output logic               wvalid_o,
  output logic [31:0]        wticks_o,
  output logic signed [31:0] credit_o,
  output logic signed [31:0] maxc_o,
  output logic               flushed_o,
  output logic               dropped_o
);
  logic [15:0] idle_r, rate_r;
  logic signed [31:0] credit_r, maxc_r;
  logic [QW-1:0] fq_r;
  logic tx_r;
  logic [31:0] hold_r;

  logic [1:0] kind_r;
  logic [15:0] el_r, dur_r;
  logic in_time_r;
  logic [15:0] delta_r;
  logic signed [33:0] prod_r;

  // Result flags
  logic rel_r, wv_r, fl_r, dr_r, wdirect_r;
  logic [31:0] wdirect_val_r;

  // Divider
  logic [31:0] dq_r;
  logic [16:0] drem_r;
  logic [31:0] dnum_r;
  logic [5:0] dcnt_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r <= '0;
      rate_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDLE_SLOPE) idle_r <= cfg_wdata;
      else rate_r <= cfg_wdata;
    end
  end

  // First step: latch the event and its distance to the hold window
  logic [15:0] slope_c;
  logic in_time_c;
  logic [31:0] hd_c;
  assign slope_c = (rate_r >= idle_r) ? rate_r - idle_r : 16'd0;
  assign in_time_c = {16'd0, elapsed_i} >= hold_r;
  assign hd_c = {16'd0, elapsed_i} - hold_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind_i;
      el_r <= elapsed_i;
      dur_r <= dur_i;
      in_time_r <= in_time_c;
      delta_r <= hd_c[15:0];
    end
  end

  // Second step: product of slope and ticks
  logic [31:0] mul_c;
  assign mul_c = (kind_r == KIND_TX) ? {16'd0, slope_c} * {16'd0, dur_r}
                                     : {16'd0, idle_r} * {16'd0, delta_r};

  always_ff @(posedge clk) begin
    if (cmd.mul2) begin
      if (kind_r == KIND_TX) prod_r <= -$signed({2'b0, mul_c});
      else prod_r <= $signed({2'b0, mul_c});
    end
  end

  // Event decision, combinational from registered product
  logic signed [31:0] cr_c, mx_c;
  logic [QW-1:0] fq_c;
  logic tx_c, rel_c, wv_c, fl_c, dr_c, need_div_c;
  logic [31:0] hold_c, wd_c;
  logic signed [49:0] sum_c;
  logic [32:0] h33_c;
  logic was_neg;

  always_comb begin
    cr_c = credit_r; mx_c = maxc_r; fq_c = fq_r; tx_c = tx_r;
    rel_c = 1'b0; wv_c = 1'b0; fl_c = 1'b0; dr_c = 1'b0; need_div_c = 1'b0;
    wd_c = '0; hold_c = hold_r;
    sum_c = 50'(credit_r) + 50'(prod_r);
    h33_c = '0;
    was_neg = credit_r[31];
    if (kind_r == KIND_TX) begin
      cr_c = sat32(sum_c);
      tx_c = 1'b0;
      if (fq_r != '0) begin
        if (cr_c[31]) begin
          wv_c = 1'b1;
          wd_c = {16'd0, dur_r};
        end else begin
          rel_c = 1'b1;
          fq_c = fq_r - 1'b1;
          tx_c = 1'b1;
        end
      end else if (cr_c > 0 && in_time_r) begin
        cr_c = '0;
      end
      h33_c = in_time_r ? {17'd0, dur_r}
                        : {1'b0, hold_r - {16'd0, el_r}} + {17'd0, dur_r};
      hold_c = h33_c[32] ? 32'hffffffff : h33_c[31:0];
    end else begin
      if (in_time_r && (was_neg || tx_r)) begin
        cr_c = sat32(sum_c);
        if (was_neg && !tx_r && cr_c > 0 && fq_r == '0) cr_c = '0;
      end
      if (kind_r == KIND_ARRIVAL) begin
        if (fq_r >= QW'(QUEUE_DEPTH)) dr_c = 1'b1;
        else fq_c = fq_r + 1'b1;
      end
      if (tx_r) begin
        if (cr_c > maxc_r) mx_c = cr_c;
      end else if (kind_r != KIND_IDLE) begin
        if (!cr_c[31]) begin
          if (fq_c != '0) begin
            rel_c = 1'b1;
            fq_c = fq_c - 1'b1;
            tx_c = 1'b1;
          end else if (in_time_r) begin
            cr_c = '0;
          end
        end else if (kind_r == KIND_WAKEUP && idle_r == '0) begin
          if (in_time_r) cr_c = '0;
          fq_c = '0;
          fl_c = 1'b1;
        end else begin
          wv_c = 1'b1;
          if (idle_r == '0) wd_c = 32'hffffffff;
          else need_div_c = 1'b1;
        end
      end
      hold_c = in_time_r ? 32'd0 : hold_r - {16'd0, el_r};
    end
  end
  assign sts.need_div = need_div_c;

  // Commit state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0; maxc_r <= '0; fq_r <= '0; tx_r <= 1'b0; hold_r <= '0;
    end else if (cmd.decide) begin
      credit_r <= cr_c; maxc_r <= mx_c; fq_r <= fq_c; tx_r <= tx_c; hold_r <= hold_c;
    end
  end

  // Hold flags and prepare divider: ceil(need/idle) = floor((need-1)/idle)+1
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      rel_r <= rel_c; wv_r <= wv_c; fl_r <= fl_c; dr_r <= dr_c;
      wdirect_r <= !need_div_c;
      wdirect_val_r <= wd_c;
    end
    if (cmd.div_start) begin
      dnum_r <= 32'(-$signed({cr_c[31], cr_c})) - 32'd1;
      drem_r <= '0;
      dq_r <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      logic [16:0] trial;
      trial = {drem_r[15:0], dnum_r[31]};
      dnum_r <= {dnum_r[30:0], 1'b0};
      if (trial >= {1'b0, idle_r}) begin
        drem_r <= trial - {1'b0, idle_r};
        dq_r <= {dq_r[30:0], 1'b1};
      end else begin
        drem_r <= trial;
        dq_r <= {dq_r[30:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 6'd1;
    end
  end
  assign sts.div_last = (dcnt_r == 6'(DivBits - 1));

  // Outputs from committed state
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      release_o <= rel_r; wvalid_o <= wv_r; flushed_o <= fl_r; dropped_o <= dr_r;
      credit_o <= credit_r; maxc_o <= maxc_r;
      wticks_o <= wdirect_r ? wdirect_val_r : dq_r + 32'd1;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/credit_based_shaper.sv =====
// Top level of the credit-based shaper
// Each event passes the load, product, decision and finish steps before its result is valid,
// and the steps of a 32-step radix-2 divider when a wait time is divided out.
// A new event is taken once the previous result has transferred.
// Reset (synchronous, rst_n low) clears credit, queue count, hold time and registers.
`default_nettype none
module credit_based_shaper
  import cbs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input wire         clk,
  input wire         rst_n,
  cbs_in_if.sink     in_ch,
  cbs_out_if.source  out_ch,
  input wire         cfg_we,
  input wire         cfg_index,
  input wire  [15:0] cfg_wdata
);
  cbs_cmd_t cmd;
  cbs_sts_t sts;

  // Sequence events
  cbs_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts
  );

  // Compute
  cbs_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .kind_i(in_ch.kind), .elapsed_i(in_ch.elapsed_ticks), .dur_i(in_ch.tx_duration),
    .cmd, .sts,
    .release_o(out_ch.release_frame), .wvalid_o(out_ch.wait_valid),
    .wticks_o(out_ch.wait_ticks), .credit_o(out_ch.credit_now),
    .maxc_o(out_ch.max_credit_now), .flushed_o(out_ch.queue_flushed),
    .dropped_o(out_ch.arrival_dropped)
  );
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the credit-based shaper: events in, results checked in order
`default_nettype none
module tb_top;
  import cbs_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] elapsed;
    logic [15:0] dur;
  } shaper_event_t;

  typedef struct packed {
    logic               release_frame;
    logic               wait_valid;
    logic [31:0]        wait_ticks;
    logic signed [31:0] credit_now;
    logic signed [31:0] max_credit_now;
    logic               queue_flushed;
    logic               arrival_dropped;
  } shaper_result_t;

  localparam int unsigned QueueDepth = QueueDepthDef;
  localparam int unsigned IdleLimit = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;

  cbs_in_if in_ch ();
  cbs_out_if out_ch ();

  credit_based_shaper u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Shaper state mirror
  logic [15:0]        sh_idle_slope = '0;
  logic [15:0]        sh_port_rate = '0;
  logic signed [31:0] sh_credit = '0;
  logic signed [31:0] sh_max_credit = '0;
  int unsigned        sh_queued = 0;
  bit                 sh_transmitting = 0;
  logic [31:0]        sh_hold = '0;

  shaper_event_t  pending_events[$];
  shaper_result_t expected_results[$];
  int  error_count = 0;
  bit  stim_done = 0;
  bit  long_stall = 0;
  bit  sender_pause = 0;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Compute the result of one event and advance the mirrored state
  function automatic shaper_result_t shape_event(shaper_event_t ev);
    shaper_result_t r;
    bit in_time;
    longint delta;
    longint slope;
    longint need;
    longint q;
    longint h;
    bit was_neg;
    r = '0;
    in_time = ev.elapsed >= sh_hold;
    delta = longint'(ev.elapsed) - longint'(sh_hold);
    if (ev.kind == KIND_TX) begin
      slope = (sh_port_rate >= sh_idle_slope) ? longint'(sh_port_rate) - sh_idle_slope : 0;
      sh_credit = clamp32(longint'(sh_credit) - slope * longint'(ev.dur));
      sh_transmitting = 0;
      if (sh_queued > 0) begin
        if (sh_credit < 0) begin
          r.wait_valid = 1;
          r.wait_ticks = ev.dur;
        end else begin
          r.release_frame = 1;
          sh_queued--;
          sh_transmitting = 1;
        end
      end else if (sh_credit > 0 && in_time) begin
        sh_credit = 0;
      end
      if (in_time) h = ev.dur;
      else h = longint'(sh_hold - ev.elapsed) + ev.dur;
      sh_hold = (h > 64'hffffffff) ? 32'hffffffff : h[31:0];
    end else begin
      was_neg = sh_credit < 0;
      if (in_time && (was_neg || sh_transmitting)) begin
        sh_credit = clamp32(longint'(sh_credit) + longint'(sh_idle_slope) * delta);
        if (was_neg && !sh_transmitting && sh_credit > 0 && sh_queued == 0) sh_credit = 0;
      end
      if (ev.kind == KIND_ARRIVAL) begin
        if (sh_queued >= QueueDepth) r.arrival_dropped = 1;
        else sh_queued++;
      end
      if (sh_transmitting) begin
        if (sh_credit > sh_max_credit) sh_max_credit = sh_credit;
      end else if (ev.kind != KIND_IDLE) begin
        if (sh_credit >= 0) begin
          if (sh_queued > 0) begin
            r.release_frame = 1;
            sh_queued--;
            sh_transmitting = 1;
          end else if (in_time) begin
            sh_credit = 0;
          end
        end else if (ev.kind == KIND_WAKEUP && sh_idle_slope == 0) begin
          if (in_time) sh_credit = 0;
          sh_queued = 0;
          r.queue_flushed = 1;
        end else begin
          r.wait_valid = 1;
          if (sh_idle_slope == 0) begin
            r.wait_ticks = 32'hffffffff;
          end else begin
            need = -longint'(sh_credit);
            q = (need + sh_idle_slope - 1) / sh_idle_slope;
            r.wait_ticks = (q > 64'hffffffff) ? 32'hffffffff : q[31:0];
          end
        end
      end
      if (in_time) sh_hold = 0;
      else sh_hold = sh_hold - ev.elapsed;
    end
    r.credit_now = sh_credit;
    r.max_credit_now = sh_max_credit;
    return r;
  endfunction

  // Driver: bursts of transfers with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(shape_event({kind_t'(in_ch.kind), in_ch.elapsed_ticks,
                                                in_ch.tx_duration}));
        void'(pending_events.pop_front());
      end
      if (gap_left > 0) gap_left--;
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered item
      end else if (pending_events.size() > 0 && !sender_pause && gap_left == 0) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        if (burst_left == 0 && $urandom_range(0, 2) != 0) gap_left = $urandom_range(1, 40);
        in_ch.valid <= 1'b1;
        {in_ch.kind, in_ch.elapsed_ticks, in_ch.tx_duration} <= pending_events[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      stall_phase = (stall_phase + 1) % 23;
      if (long_stall) out_ch.ready <= 1'b0;
      else if (stall_phase < 8) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    shaper_result_t got;
    shaper_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.release_frame, out_ch.wait_valid, out_ch.wait_ticks, out_ch.credit_now,
             out_ch.max_credit_now, out_ch.queue_flushed, out_ch.arrival_dropped};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected rel=%0b wv=%0b wt=%0d cr=%0d mx=%0d fl=%0b dr=%0b",
                   $time, want.release_frame, want.wait_valid, want.wait_ticks,
                   want.credit_now, want.max_credit_now, want.queue_flushed,
                   want.arrival_dropped);
          $display("%0t:          actual   rel=%0b wv=%0b wt=%0d cr=%0d mx=%0d fl=%0b dr=%0b",
                   $time, got.release_frame, got.wait_valid, got.wait_ticks,
                   got.credit_now, got.max_credit_now, got.queue_flushed,
                   got.arrival_dropped);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n ||
        stim_done || (pending_events.size() == 0 && expected_results.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [15:0] rand_ticks();
    case ($urandom_range(0, 4))
      0: return 16'(0);
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_event(kind_t k, logic [15:0] el, logic [15:0] du);
    pending_events.push_back({k, el, du});
  endtask

  task automatic drain();
    wait (pending_events.size() == 0 && !in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDLE_SLOPE) sh_idle_slope = val;
    else sh_port_rate = val;
  endtask

  // Well-formed shaping traffic: arrivals, transmissions, wakeups, idles
  task automatic add_traffic(int n);
    int i;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_event(KIND_ARRIVAL, rand_ticks(), 16'($urandom));
        3, 4: add_event(KIND_TX, rand_ticks(), ($urandom_range(0, 1)) ? 16'($urandom_range(0, 64))
                                                                  : 16'($urandom));
        5, 6: add_event(KIND_WAKEUP, rand_ticks(), 16'($urandom));
        default: add_event(KIND_IDLE, rand_ticks(), 16'($urandom));
      endcase
    end
  endtask

  initial begin
    int phase;
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.elapsed_ticks = '0;
    in_ch.tx_duration = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero reservation at reset values
    add_event(KIND_ARRIVAL, 16'd0, 16'd0);
    add_event(KIND_TX, 16'd5, 16'hffff);
    add_event(KIND_WAKEUP, 16'd0, 16'd0);
    add_event(KIND_IDLE, 16'hffff, 16'hffff);
    drain();
    write_reg(CFG_IDLE_SLOPE, 16'd0);
    write_reg(CFG_PORT_RATE, 16'hffff);
    // Negative credit with zero slope: infinite wait then flush
    add_event(KIND_ARRIVAL, 16'd0, 16'd0);
    add_event(KIND_TX, 16'd0, 16'hffff);
    add_event(KIND_ARRIVAL, 16'd1, 16'd0);
    add_event(KIND_WAKEUP, 16'd3, 16'd0);
    add_event(KIND_WAKEUP, 16'hffff, 16'd0);
    drain();
    write_reg(CFG_IDLE_SLOPE, 16'hffff);
    write_reg(CFG_PORT_RATE, 16'd1);
    // Slope inversion, hold window, saturation toward the top
    add_event(KIND_ARRIVAL, 16'd0, 16'd0);
    add_event(KIND_TX, 16'd0, 16'hffff);
    add_event(KIND_IDLE, 16'hffff, 16'd0);
    add_event(KIND_TX, 16'd10, 16'hffff);
    add_event(KIND_IDLE, 16'hffff, 16'd0);
    add_event(KIND_IDLE, 16'hffff, 16'd0);
    drain();
    write_reg(CFG_IDLE_SLOPE, 16'd1);
    write_reg(CFG_PORT_RATE, 16'hffff);
    // Deep negative credit, long waits, queue overflow
    for (int i = 0; i < 3; i++) add_event(KIND_TX, 16'd0, 16'hffff);
    add_event(KIND_WAKEUP, 16'd7, 16'd0);
    drain();
    for (int i = 0; i < QueueDepth + 3; i++) add_event(KIND_ARRIVAL, 16'd0, 16'd0);
    drain();

    // Random phases with changing rates
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(CFG_IDLE_SLOPE, 16'd0); write_reg(CFG_PORT_RATE, 16'd0); end
        1: begin write_reg(CFG_IDLE_SLOPE, 16'hffff); write_reg(CFG_PORT_RATE, 16'hffff); end
        2: begin write_reg(CFG_IDLE_SLOPE, 16'd3); write_reg(CFG_PORT_RATE, 16'd10); end
        default: begin
          write_reg(CFG_IDLE_SLOPE, 16'($urandom));
          write_reg(CFG_PORT_RATE, 16'($urandom));
        end
      endcase
      add_traffic(170);
      if (phase == 3) begin
        // hold off the receiver while the sender keeps offering
        long_stall = 1;
        repeat (600) @(posedge clk);
        long_stall = 0;
      end
      if (phase == 5) begin
        wait (pending_events.size() == 0 && !in_ch.valid);
        sender_pause = 1;
        wait (expected_results.size() == 0);
        sender_pause = 0;
      end
      drain();
    end

    stim_done = 1;
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/cbs_pkg.sv
rtl/cbs_if.sv
rtl/cbs_ctrl.sv
rtl/cbs_dp.sv
rtl/credit_based_shaper.sv
tb/sv/tb_top.sv
